// ===== src/dtac_pkg.sv =====
// Shared widths, codes and types of the distance tracking aim controller.
`default_nettype none

package dtac_pkg;

   // Field and register widths
   localparam int DIST_W  = 12;
   localparam int ANG_W   = 9;
   localparam int LIM_W   = 8;
   localparam int SPR_W   = 13;
   localparam int MODE_W  = 2;
   localparam int STATE_W = 2;
   localparam int STEPS_W = 13;

   // Stream and configuration port widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Datapath widths
   localparam int NUM_W     = 21;                   // angle numerator, never negative
   localparam int NUM_SUM_W = 24;                   // base plus signed slope term
   localparam int MA_W      = 22;                   // signed multiplier operand a
   localparam int MB_W      = 14;                   // signed multiplier operand b
   localparam int PROD_W    = MA_W + MB_W;
   localparam int Q_W       = 21;                   // window width times 360
   localparam int P_W       = Q_W + STEPS_W - 1;    // clamped numerator times steps
   localparam int DIV_STEPS = STEPS_W;              // one quotient bit per cycle
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int DEG_PER_REV = 360;

   // Input mode codes
   localparam logic [MODE_W-1:0] MODE_SAMPLE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACTIVATE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEACTIVATE = 2'd2;

   // Controller state codes
   localparam logic [STATE_W-1:0] CS_INACTIVE = 2'd0;
   localparam logic [STATE_W-1:0] CS_REST     = 2'd1;
   localparam logic [STATE_W-1:0] CS_TRACK    = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DIST_MIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIST_MAX      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_AT_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_AT_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_HIGH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STEPS_PER_REV = 3'd6;

   typedef struct packed {
      logic [DIST_W-1:0] dist_min;
      logic [DIST_W-1:0] dist_max;
      logic [ANG_W-1:0]  angle_at_min;
      logic [ANG_W-1:0]  angle_at_max;
      logic [LIM_W-1:0]  limit_low;
      logic [LIM_W-1:0]  limit_high;
      logic [SPR_W-1:0]  steps_per_rev;
   } cfg_type;

   typedef struct packed {
      logic           start;
      logic [P_W-1:0] dividend;
      logic [Q_W-1:0] divisor;
   } div_req_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_MUL_BASE,
      SEQ_MUL_SLOPE,
      SEQ_MUL_LOW,
      SEQ_MUL_HIGH,
      SEQ_CLAMP,
      SEQ_MUL_STEPS,
      SEQ_LOAD_DIV,
      SEQ_DIV,
      SEQ_OUT
   } seq_state_type;

endpackage

`default_nettype wire

// ===== src/distance_tracking_aim_controller.sv =====
// Top level of the distance tracking aim controller: sequencer and datapath.
//
//   channel   direction  fields (low bit up)                       handshake
//   req       in         tuser: mode[1:0]; tdata: distance_mm[11:0]  req_tvalid/req_tready
//   rsp       out        tuser: target_valid; tdata: ctrl_state[1:0],
//                        target_steps[14:2]                         rsp_tvalid/rsp_tready
//   csr       in         csr_index, csr_wdata                       csr_wr_en, no wait
//
// A command, an ignored sample or a sample that only changes state goes from accept to the output load.
// A sample that issues a target passes through accept, six multiplier passes, the divider
// load, 13 divider steps with its done strobe, then the output load.
// One request is in flight at a time; req_tready is high only while the sequencer idles.
// Reset is synchronous and active high; it restores the register defaults and inactive.
// A result waiting in the output register holds the sequencer until rsp_tready.
`default_nettype none

module distance_tracking_aim_controller
   import dtac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // distance_mm[11:0], zero pad
   input  wire logic [MODE_W-1:0]     req_tuser,   // mode[1:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // ctrl_state[1:0], target_steps[14:2], pad
   output logic                       rsp_tuser,   // target_valid
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                   cfg;
   seq_state_type             seq_ff, seq_in;
   logic [STATE_W-1:0]        ctrl_ff, ctrl_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic [NUM_W-1:0]          acc_ff, acc_in;
   logic [NUM_W-1:0]          lo_ff, lo_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic [STEPS_W-1:0]        steps_ff, steps_in;
   logic                      valid_ff, valid_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic                      rsp_tuser_ff, rsp_tuser_in;

   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]  prod;
   div_req_type               div_req;
   logic                      div_done;
   logic [STEPS_W-1:0]        div_quo;

   logic [DIST_W-1:0]         req_dist;
   logic                      in_win;
   logic                      den_zero;
   logic [DIST_W-1:0]         den_raw;
   logic [DIST_W-1:0]         den_eff;
   logic [DIST_W-1:0]         dist_off;
   logic signed [ANG_W:0]     ang_span;
   logic signed [NUM_SUM_W-1:0] num_sum;
   logic [NUM_W-1:0]          hi_val;
   logic [NUM_W-1:0]          raised;
   logic [NUM_W-1:0]          clamped;
   logic                      out_free;

   dtac_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dtac_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   dtac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Window tests and operand preparation
   always_comb begin
      req_dist = req_tdata[DIST_W-1:0];
      in_win   = (req_dist >= cfg.dist_min) && (req_dist <= cfg.dist_max);
      den_raw  = cfg.dist_max - cfg.dist_min;
      den_zero = (cfg.dist_max == cfg.dist_min);
      den_eff  = den_zero ? DIST_W'(1) : den_raw;
      dist_off = dist_ff - cfg.dist_min;
      ang_span = signed'({1'b0, cfg.angle_at_max}) - signed'({1'b0, cfg.angle_at_min});
      num_sum  = signed'(NUM_SUM_W'(acc_ff)) + prod[NUM_SUM_W-1:0];
      hi_val   = prod[NUM_W-1:0];
      raised   = (acc_ff < lo_ff) ? lo_ff : acc_ff;
      clamped  = (raised > hi_val) ? hi_val : raised;
      out_free = !rsp_tvalid_ff || rsp_tready;
   end

   // Sequencer: next state, datapath loads and operand selection
   always_comb begin
      seq_in        = seq_ff;
      ctrl_in       = ctrl_ff;
      dist_in       = dist_ff;
      acc_in        = acc_ff;
      lo_in         = lo_ff;
      q_in          = q_ff;
      steps_in      = steps_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_req       = '0;
      req_tready    = 1'b0;

      unique case (seq_ff)
         SEQ_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               dist_in  = req_dist;
               steps_in = '0;
               valid_in = 1'b0;
               seq_in   = SEQ_OUT;
               unique case (req_tuser)
                  MODE_ACTIVATE:   ctrl_in = CS_REST;
                  MODE_DEACTIVATE: ctrl_in = CS_INACTIVE;
                  MODE_SAMPLE: begin
                     if (ctrl_ff == CS_REST && in_win) begin
                        ctrl_in = CS_TRACK;
                     end else if (ctrl_ff == CS_TRACK) begin
                        if (!in_win) begin
                           ctrl_in = CS_REST;
                        end else begin
                           seq_in = SEQ_MUL_BASE;
                        end
                     end
                  end
                  default:         ctrl_in = ctrl_ff;
               endcase
            end
         end
         // angle_at_min times window width
         SEQ_MUL_BASE: begin
            mul_a  = MA_W'(cfg.angle_at_min);
            mul_b  = MB_W'(den_raw);
            seq_in = SEQ_MUL_SLOPE;
         end
         // angle span times offset into the window
         SEQ_MUL_SLOPE: begin
            mul_a  = MA_W'(ang_span);
            mul_b  = MB_W'(dist_off);
            acc_in = prod[NUM_W-1:0];
            seq_in = SEQ_MUL_LOW;
         end
         // numerator complete; zero-width window takes angle_at_min over one
         SEQ_MUL_LOW: begin
            mul_a  = MA_W'(cfg.limit_low);
            mul_b  = MB_W'(den_eff);
            acc_in = den_zero ? NUM_W'(cfg.angle_at_min) : num_sum[NUM_W-1:0];
            seq_in = SEQ_MUL_HIGH;
         end
         SEQ_MUL_HIGH: begin
            mul_a  = MA_W'(cfg.limit_high);
            mul_b  = MB_W'(den_eff);
            lo_in  = prod[NUM_W-1:0];
            seq_in = SEQ_CLAMP;
         end
         // raise to the low limit, then lower to the high limit
         SEQ_CLAMP: begin
            mul_a  = MA_W'(den_eff);
            mul_b  = MB_W'(DEG_PER_REV);
            acc_in = clamped;
            seq_in = SEQ_MUL_STEPS;
         end
         SEQ_MUL_STEPS: begin
            mul_a  = MA_W'(acc_ff);
            mul_b  = MB_W'(cfg.steps_per_rev);
            q_in   = prod[Q_W-1:0];
            seq_in = SEQ_LOAD_DIV;
         end
         SEQ_LOAD_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod[P_W-1:0];
            div_req.divisor  = q_ff;
            seq_in           = SEQ_DIV;
         end
         SEQ_DIV: begin
            if (div_done) begin
               steps_in = div_quo;
               valid_in = 1'b1;
               seq_in   = SEQ_OUT;
            end
         end
         // hand the result to the output register once it is free
         SEQ_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_W'({steps_ff, ctrl_ff});
               rsp_tuser_in  = valid_ff;
               seq_in        = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SEQ_IDLE;
         ctrl_ff       <= CS_INACTIVE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         ctrl_ff       <= ctrl_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      dist_ff      <= dist_in;
      acc_ff       <= acc_in;
      lo_ff        <= lo_in;
      q_ff         <= q_in;
      steps_ff     <= steps_in;
      valid_ff     <= valid_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ===== src/dtac_regs.sv =====
// Configuration register file of the aim controller.
`default_nettype none

module dtac_regs
   import dtac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Write decode, each register takes the low bits of the write data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_DIST_MIN:      cfg_in.dist_min      = csr_wdata[DIST_W-1:0];
            REG_DIST_MAX:      cfg_in.dist_max      = csr_wdata[DIST_W-1:0];
            REG_ANGLE_AT_MIN:  cfg_in.angle_at_min  = csr_wdata[ANG_W-1:0];
            REG_ANGLE_AT_MAX:  cfg_in.angle_at_max  = csr_wdata[ANG_W-1:0];
            REG_LIMIT_LOW:     cfg_in.limit_low     = csr_wdata[LIM_W-1:0];
            REG_LIMIT_HIGH:    cfg_in.limit_high    = csr_wdata[LIM_W-1:0];
            REG_STEPS_PER_REV: cfg_in.steps_per_rev = csr_wdata[SPR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dist_min      <= DIST_W'(200);
         cfg_ff.dist_max      <= DIST_W'(1000);
         cfg_ff.angle_at_min  <= ANG_W'(10);
         cfg_ff.angle_at_max  <= ANG_W'(170);
         cfg_ff.limit_low     <= LIM_W'(10);
         cfg_ff.limit_high    <= LIM_W'(170);
         cfg_ff.steps_per_rev <= SPR_W'(2048);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/dtac_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none

module dtac_mul
   import dtac_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [MA_W-1:0]   op_a,
   input  wire logic signed [MB_W-1:0]   op_b,
   output logic signed [PROD_W-1:0]      prod
);

   logic signed [PROD_W-1:0] prod_ff;

   // One product per cycle, ready the cycle after the operands
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== src/dtac_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module dtac_div
   import dtac_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire div_req_type   div_req,
   output logic               done,
   output logic [STEPS_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [P_W-1:0]       rem_ff, rem_in;
   logic [P_W-1:0]       ds_ff, ds_in;
   logic [STEPS_W-1:0]   quo_ff, quo_in;
   logic                 fits;

   // Quotient is known to fit STEPS_W bits, so the divisor starts shifted by STEPS_W-1
   always_comb begin
      fits    = rem_ff >= ds_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      ds_in   = ds_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         rem_in  = div_req.dividend;
         ds_in   = P_W'({div_req.divisor, {(STEPS_W-1){1'b0}}});
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_ff - ds_ff) : rem_ff;
         ds_in  = ds_ff >> 1;
         quo_in = {quo_ff[STEPS_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      ds_ff  <= ds_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/dtac_checker.sv =====
// Port-level checker of the aim controller and its bind.
`default_nettype none

module dtac_checker
   import dtac_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   // A stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // One request at a time: the block is busy right after taking one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous one in flight");

   // Targets are only issued in tracking
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[STATE_W-1:0] == CS_TRACK)
      else $error("target issued outside tracking");

   // No target means a zero step field
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_DATA_W-1:STATE_W] == '0)
      else $error("step field set without a target");

   // Nothing offered straight after reset
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind distance_tracking_aim_controller dtac_checker u_checker (.*);

`default_nettype wire
